/* hw/rtl/bbe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbe_pkg: shared types and constants of the bernstein basis evaluator
// controller command and status words, field widths and the binomial table
// ----------------------------------------------------------------------------
package bbe_pkg;

	localparam int ORDER_W   = 4;
	localparam int BINOM_W   = 13;
	localparam int COEF_W    = 17;
	localparam int OUT_W     = 24;
	localparam int TAB_SIDE  = 1 << ORDER_W;
	localparam int TAB_DEPTH = TAB_SIDE * TAB_SIDE;

	typedef logic [BINOM_W-1:0] binom_tab_t [0:TAB_DEPTH-1];

	typedef struct packed {
		logic load;
		logic pass_load;
		logic pass_sel;
		logic step_x;
		logic step_y;
		logic scale;
		logic out_load;
	} bbe_cmd_t;

	typedef struct packed {
		logic err;
		logic cmd;
		logic k_zero;
		logic k_is_n;
		logic ea_zero;
		logic eb_zero;
	} bbe_stat_t;

	// pascal triangle, entries with k above n come out zero
	function automatic binom_tab_t build_binom_tab();
		binom_tab_t t;
		logic [BINOM_W-1:0] upper;
		logic [BINOM_W-1:0] upper_left;
		for (int n = 0; n < TAB_SIDE; n++) begin
			for (int k = 0; k < TAB_SIDE; k++) begin
				if (n == 0) begin
					t[k] = (k == 0) ? BINOM_W'(1) : '0;
				end else begin
					upper      = t[(n-1)*TAB_SIDE + k];
					upper_left = (k > 0) ? t[(n-1)*TAB_SIDE + k - 1] : '0;
					t[n*TAB_SIDE + k] = upper + upper_left;
				end
			end
		end
		return t;
	endfunction

	localparam binom_tab_t BINOM_TAB = build_binom_tab();

endpackage
`default_nettype wire

/* hw/rtl/bbe_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbe_datapath: operand registers, shared multiplier and result stage
// power products with half-up rounding, coefficient scaling, saturation
// ----------------------------------------------------------------------------
module bbe_datapath import bbe_pkg::*; #(
	parameter int MAX_ORDER = 15,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_wr_en,
	input  wire logic [ORDER_W-1:0]       cfg_wr_data,
	input  wire logic                     cmd,
	input  wire logic [FRAC_BITS:0]       point,
	input  wire logic [ORDER_W-1:0]       basis_index,
	input  wire bbe_cmd_t                 ctl,
	output bbe_stat_t                     stat,
	output logic signed [OUT_W-1:0]       result_value,
	output logic                          index_error
);

	localparam int PT_W   = FRAC_BITS + 1;
	localparam int MUL_W  = (PT_W > COEF_W) ? PT_W : COEF_W;
	localparam int PROD_W = MUL_W + PT_W;
	localparam int TERM_W = COEF_W + PT_W;
	localparam int DIFF_W = TERM_W + 1;

	localparam logic [PT_W-1:0]   ONE_FX  = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [PROD_W-1:0] HALF_FX = PROD_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [DIFF_W-1:0] POS_MAX = DIFF_W'((64'sd1 <<< (OUT_W - 1)) - 1);
	localparam logic signed [DIFF_W-1:0] NEG_MAX = -(DIFF_W'(64'sd1 <<< (OUT_W - 1)));

	logic [ORDER_W-1:0] poly_order_q;
	logic               cmd_q;
	logic [ORDER_W-1:0] k_q;
	logic [ORDER_W-1:0] n_q;
	logic [PT_W-1:0]    x_q;
	logic [PT_W-1:0]    y_q;
	logic               err_q;
	logic [ORDER_W-1:0] ea_q;
	logic [ORDER_W-1:0] eb_q;
	logic [COEF_W-1:0]  coef_q;
	logic [PT_W-1:0]    p_q;
	logic [TERM_W-1:0]  term_l_q;
	logic [TERM_W-1:0]  term_r_q;
	logic signed [OUT_W-1:0] result_q;
	logic               index_error_q;

	logic [ORDER_W-1:0] n_eff;
	logic [PT_W-1:0]    x_clamp;
	logic [BINOM_W-1:0] binom;
	logic [ORDER_W-1:0] n_minus_k;
	logic [MUL_W-1:0]   mul_a;
	logic [PT_W-1:0]    mul_b;
	logic [PROD_W-1:0]  prod;
	logic [PROD_W-1:0]  prod_rnd;
	logic signed [DIFF_W-1:0] diff;
	logic signed [OUT_W-1:0]  sat;

	always_comb begin
		n_eff = (int'(poly_order_q) > MAX_ORDER) ? ORDER_W'(MAX_ORDER) : poly_order_q;
		x_clamp = (point > ONE_FX) ? ONE_FX : point;
		binom = BINOM_TAB[{n_q, k_q}];
		n_minus_k = n_q - k_q;
	end

	// one shared multiplier: power steps or coefficient scaling
	always_comb begin
		mul_a = ctl.scale ? MUL_W'(coef_q) : MUL_W'(p_q);
		if (ctl.scale) begin
			mul_b = p_q;
		end else if (ctl.step_x) begin
			mul_b = x_q;
		end else begin
			mul_b = y_q;
		end
		prod = PROD_W'(mul_a) * PROD_W'(mul_b);
		prod_rnd = (prod + HALF_FX) >> FRAC_BITS;
	end

	always_comb begin
		diff = signed'({1'b0, term_l_q}) - signed'({1'b0, term_r_q});
		if (diff > POS_MAX) begin
			sat = POS_MAX[OUT_W-1:0];
		end else if (diff < NEG_MAX) begin
			sat = NEG_MAX[OUT_W-1:0];
		end else begin
			sat = diff[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_order_q <= ORDER_W'(1);
		end else if (cfg_wr_en) begin
			poly_order_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q    <= cmd;
			k_q      <= basis_index;
			n_q      <= n_eff;
			x_q      <= x_clamp;
			y_q      <= ONE_FX - x_clamp;
			err_q    <= basis_index > n_eff;
			term_l_q <= '0;
			term_r_q <= '0;
		end
		if (ctl.pass_load) begin
			p_q <= ONE_FX;
			if (!ctl.pass_sel) begin
				ea_q   <= cmd_q ? k_q - ORDER_W'(1) : k_q;
				eb_q   <= n_minus_k;
				coef_q <= cmd_q ? COEF_W'(binom) * COEF_W'(k_q) : COEF_W'(binom);
			end else begin
				ea_q   <= k_q;
				eb_q   <= n_minus_k - ORDER_W'(1);
				coef_q <= COEF_W'(binom) * COEF_W'(n_minus_k);
			end
		end
		if (ctl.step_x) begin
			p_q  <= prod_rnd[PT_W-1:0];
			ea_q <= ea_q - ORDER_W'(1);
		end
		if (ctl.step_y) begin
			p_q  <= prod_rnd[PT_W-1:0];
			eb_q <= eb_q - ORDER_W'(1);
		end
		if (ctl.scale) begin
			if (!ctl.pass_sel) begin
				term_l_q <= prod[TERM_W-1:0];
			end else begin
				term_r_q <= prod[TERM_W-1:0];
			end
		end
		if (ctl.out_load) begin
			result_q      <= sat;
			index_error_q <= err_q;
		end
	end

	always_comb begin
		stat.err     = err_q;
		stat.cmd     = cmd_q;
		stat.k_zero  = (k_q == '0);
		stat.k_is_n  = (k_q == n_q);
		stat.ea_zero = (ea_q == '0);
		stat.eb_zero = (eb_q == '0);
	end

	assign result_value = result_q;
	assign index_error  = index_error_q;

endmodule
`default_nettype wire

/* hw/rtl/bbe_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbe_ctrl: sequencing state machine of the bernstein basis evaluator
// runs the value or derivative passes and hands the result word out
// ----------------------------------------------------------------------------
module bbe_ctrl import bbe_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	input  wire bbe_stat_t stat,
	output bbe_cmd_t       ctl
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PICK = 2'd1;
	localparam logic [1:0] ST_RUN  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       pass_q;
	logic       pass_d;
	logic       out_valid_q;

	always_comb begin
		state_d = state_q;
		pass_d  = pass_q;
		ctl     = '0;
		ctl.pass_sel = pass_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load = 1'b1;
					pass_d   = 1'b0;
					state_d  = ST_PICK;
				end
			end
			ST_PICK: begin
				if (stat.err) begin
					state_d = ST_FIN;
				end else if (!pass_q) begin
					if (!stat.cmd || !stat.k_zero) begin
						ctl.pass_load = 1'b1;
						state_d = ST_RUN;
					end else begin
						pass_d = 1'b1;
					end
				end else if (stat.cmd && !stat.k_is_n) begin
					ctl.pass_load = 1'b1;
					state_d = ST_RUN;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_RUN: begin
				if (!stat.ea_zero) begin
					ctl.step_x = 1'b1;
				end else if (!stat.eb_zero) begin
					ctl.step_y = 1'b1;
				end else begin
					ctl.scale = 1'b1;
					if (!pass_q) begin
						pass_d  = 1'b1;
						state_d = ST_PICK;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					ctl.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pass_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pass_q  <= pass_d;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

/* hw/rtl/bernstein_basis_eval.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bernstein_basis_eval: bernstein basis value and derivative evaluator
// one word in, one word out, order set by a single configuration register
// ----------------------------------------------------------------------------
// Evaluates C(n,k) x^k (1-x)^(n-k) (cmd 0) or its derivative in x (cmd 1) at
// an unsigned point with FRAC_BITS fraction bits, clamped to 1.0; the result
// is signed with FRAC_BITS fraction bits and saturates to 24 bits. An index
// above the order gives zero with index_error set. All power and scaling
// products go through one multiplier, at most one multiply per cycle, so the
// time per word grows with the order n: value words run one pass, derivative
// words up to two passes (at most one when k is 0 or n), error words none,
// and a word may also wait for a full output register. A new word is taken
// only when the previous one has been moved into the output register; a
// finished word may wait there while the next one is computed.
module bernstein_basis_eval import bbe_pkg::*; #(
	parameter int MAX_ORDER = 15,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [ORDER_W-1:0]   cfg_wr_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 cmd,
	input  wire logic [FRAC_BITS:0]   point,
	input  wire logic [ORDER_W-1:0]   basis_index,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic signed [OUT_W-1:0]   result_value,
	output logic                      index_error
);

	bbe_cmd_t  ctl;
	bbe_stat_t stat;

	bbe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	bbe_datapath #(
		.MAX_ORDER (MAX_ORDER),
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.cmd          (cmd),
		.point        (point),
		.basis_index  (basis_index),
		.ctl          (ctl),
		.stat         (stat),
		.result_value (result_value),
		.index_error  (index_error)
	);

	// error word always carries zero
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && index_error |-> result_value == '0)
		else $error("index error word with nonzero result");

	// no second word taken right after an accept
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	// multiplier serves at most one operation per cycle
	a_mul_share: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({ctl.step_x, ctl.step_y, ctl.scale}) <= 1)
		else $error("multiplier claimed twice");

	// result only loaded when the output register is free or draining
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> !out_valid || out_ready)
		else $error("output word overwritten");

endmodule
`default_nettype wire

/* sim/bernstein_basis_eval_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bernstein_basis_eval_tb: self-checking bench for the bernstein evaluator
// directed corner words, then random words over several orders, with gaps
// and stalls on both channels; each result word is checked against a
// predicted value and error flag
// ----------------------------------------------------------------------------
module bernstein_basis_eval_tb;
	import bbe_pkg::*;

	localparam int MAX_ORD   = 15;
	localparam int FRAC      = 16;
	localparam int PT_W      = FRAC + 1;
	localparam longint unsigned ONE_Q  = 64'd1 << FRAC;
	localparam longint unsigned HALF_Q = 64'd1 << (FRAC - 1);
	localparam longint unsigned POS_LIM = 64'd8388607;
	localparam longint unsigned NEG_LIM = 64'd8388608;
	localparam int SETTLE    = 48;
	localparam int LIMIT     = 500000;
	localparam int RAND_WORDS = 65;

	typedef enum logic {CMD_VALUE = 1'b0, CMD_DERIV = 1'b1} eval_cmd_t;

	typedef struct {
		eval_cmd_t         op;
		logic [PT_W-1:0]   pt;
		logic [ORDER_W-1:0] idx;
	} basis_word_t;

	typedef struct {
		logic signed [OUT_W-1:0] value;
		logic                    err;
	} basis_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_wr_en = 1'b0;
	logic [ORDER_W-1:0]       cfg_wr_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic                     cmd = 1'b0;
	logic [PT_W-1:0]          point = '0;
	logic [ORDER_W-1:0]       basis_index = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [OUT_W-1:0]  result_value;
	logic                     index_error;

	basis_word_t   word_q[$];
	basis_result_t basis_exp_q[$];
	logic [ORDER_W-1:0] cur_order = ORDER_W'(1);
	int            queued_words = 0;
	int            sent_words = 0;
	int            errors = 0;
	int            cycles = 0;
	int            idle_pct = 0;
	int            tx_gap = 0;
	int            rx_stall = 0;
	logic          rx_hold = 1'b0;
	logic          hold_req = 1'b0;
	basis_word_t   next_word;
	basis_result_t got_exp;

	bernstein_basis_eval #(
		.MAX_ORDER(MAX_ORD),
		.FRAC_BITS(FRAC)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.point(point),
		.basis_index(basis_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_value(result_value),
		.index_error(index_error)
	);

	always #5 clk = ~clk;

	function automatic longint unsigned binom_coef(longint unsigned n, longint unsigned k);
		longint unsigned m;
		longint unsigned c;
		m = (k < n - k) ? k : n - k;
		c = 1;
		for (longint unsigned i = 1; i <= m; i++)
			c = c * (n - m + i) / i;
		return c;
	endfunction

	function automatic longint unsigned pow_pair(longint unsigned x, longint unsigned a,
			longint unsigned b);
		longint unsigned y;
		longint unsigned p;
		y = ONE_Q - x;
		p = ONE_Q;
		for (longint unsigned i = 0; i < a; i++)
			p = (p * x + HALF_Q) >> FRAC;
		for (longint unsigned i = 0; i < b; i++)
			p = (p * y + HALF_Q) >> FRAC;
		return p;
	endfunction

	function automatic basis_result_t eval_bernstein(logic [ORDER_W-1:0] order, eval_cmd_t op,
			logic [PT_W-1:0] pt, logic [ORDER_W-1:0] idx);
		basis_result_t   r;
		longint unsigned n;
		longint unsigned k;
		longint unsigned x;
		longint unsigned c;
		longint unsigned lhs;
		longint unsigned rhs;
		longint unsigned mag;
		bit              neg;
		n = order;
		if (n > MAX_ORD)
			n = MAX_ORD;
		x = pt;
		if (x > ONE_Q)
			x = ONE_Q;
		k = idx;
		r.value = '0;
		r.err = 1'b0;
		if (k > n) begin
			r.err = 1'b1;
			return r;
		end
		c = binom_coef(n, k);
		if (op == CMD_VALUE) begin
			neg = 1'b0;
			mag = c * pow_pair(x, k, n - k);
		end else begin
			lhs = 0;
			rhs = 0;
			if (k > 0)
				lhs = c * k * pow_pair(x, k - 1, n - k);
			if (k < n)
				rhs = c * (n - k) * pow_pair(x, k, n - k - 1);
			neg = rhs > lhs;
			mag = neg ? rhs - lhs : lhs - rhs;
		end
		if (neg) begin
			if (mag > NEG_LIM)
				mag = NEG_LIM;
			r.value = OUT_W'(64'd0 - mag);
		end else begin
			if (mag > POS_LIM)
				mag = POS_LIM;
			r.value = OUT_W'(mag);
		end
		return r;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap(int pct);
		if ($urandom_range(99) >= pct)
			return 0;
		if ($urandom_range(9) == 0)
			return $urandom_range(60, 20);
		return $urandom_range(3, 1);
	endfunction

	function automatic basis_word_t rand_word(logic [ORDER_W-1:0] order);
		basis_word_t w;
		int          sel;
		w.op = eval_cmd_t'($urandom_range(1));
		sel = $urandom_range(99);
		if (sel < 10) begin
			w.pt = PT_W'($urandom_range(131071, 65537));
		end else if (sel < 20) begin
			case ($urandom_range(3))
				0: w.pt = '0;
				1: w.pt = PT_W'(ONE_Q);
				2: w.pt = PT_W'(1);
				default: w.pt = PT_W'(ONE_Q - 1);
			endcase
		end else begin
			w.pt = PT_W'($urandom_range(65536, 0));
		end
		if ($urandom_range(99) < 85)
			w.idx = ORDER_W'($urandom_range(order, 0));
		else
			w.idx = ORDER_W'($urandom_range(15, 0));
		return w;
	endfunction

	task automatic queue_word(eval_cmd_t op, int pt, int idx);
		basis_word_t w;
		w.op = op;
		w.pt = PT_W'(pt);
		w.idx = ORDER_W'(idx);
		word_q.push_back(w);
		queued_words++;
	endtask

	task automatic drain();
		while (sent_words != queued_words || basis_exp_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_order(int order);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= ORDER_W'(order);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_order = ORDER_W'(order);
	endtask

	task automatic random_phase(int order, int pct, bit long_hold);
		drain();
		write_order(order);
		idle_pct = pct;
		for (int i = 0; i < RAND_WORDS; i++) begin
			word_q.push_back(rand_word(cur_order));
			queued_words++;
		end
		if (long_hold)
			hold_req = 1'b1;
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			tx_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				basis_exp_q.push_back(eval_bernstein(cur_order, eval_cmd_t'(cmd), point,
					basis_index));
				sent_words++;
			end
			if (!in_valid || in_ready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (word_q.size() != 0) begin
					next_word = word_q.pop_front();
					in_valid <= 1'b1;
					cmd <= next_word.op;
					point <= next_word.pt;
					basis_index <= next_word.idx;
					tx_gap = pick_gap(idle_pct);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_stall = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (basis_exp_q.size() == 0) begin
					$error("result word with nothing expected");
					errors++;
				end else begin
					got_exp = basis_exp_q.pop_front();
					if (result_value !== got_exp.value) begin
						$error("result_value mismatch: expected %0d, actual %0d",
							got_exp.value, result_value);
						errors++;
					end
					if (index_error !== got_exp.err) begin
						$error("index_error mismatch: expected %0d, actual %0d",
							got_exp.err, index_error);
						errors++;
					end
				end
			end
			if (rx_stall > 0)
				rx_stall--;
			else
				rx_stall = pick_gap(idle_pct);
			out_ready <= !rx_hold && rx_stall == 0;
		end
	end

	// long receiver hold-off so the block backs up into its input
	initial begin
		wait (hold_req);
		repeat (20) @(posedge clk);
		rx_hold <= 1'b1;
		repeat (400) @(posedge clk);
		rx_hold <= 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// order 1 straight out of reset
		queue_word(CMD_VALUE, 0, 0);
		queue_word(CMD_VALUE, 65536, 0);
		queue_word(CMD_DERIV, 0, 1);
		queue_word(CMD_DERIV, 65536, 1);
		queue_word(CMD_VALUE, 32768, 1);
		queue_word(CMD_DERIV, 131071, 0);
		queue_word(CMD_VALUE, 65537, 1);
		queue_word(CMD_VALUE, 0, 2);
		queue_word(CMD_DERIV, 12345, 15);
		drain();

		// order zero, zero to the power zero
		write_order(0);
		queue_word(CMD_VALUE, 0, 0);
		queue_word(CMD_DERIV, 40000, 0);
		queue_word(CMD_VALUE, 131071, 0);
		queue_word(CMD_DERIV, 0, 1);
		drain();

		write_order(MAX_ORD);
		queue_word(CMD_VALUE, 0, 0);
		queue_word(CMD_VALUE, 65536, 15);
		queue_word(CMD_VALUE, 32768, 7);
		queue_word(CMD_DERIV, 0, 0);
		queue_word(CMD_DERIV, 65536, 15);
		queue_word(CMD_DERIV, 32768, 8);
		queue_word(CMD_DERIV, 1, 1);
		queue_word(CMD_DERIV, 65535, 14);
		queue_word(CMD_VALUE, 98304, 15);

		random_phase(15, 30, 1'b0);
		random_phase(3, 0, 1'b0);
		random_phase(0, 40, 1'b0);
		random_phase(9, 20, 1'b0);
		random_phase(1, 30, 1'b0);
		random_phase(15, 10, 1'b1);
		random_phase($urandom_range(15), 50, 1'b0);
		random_phase($urandom_range(15), 0, 1'b0);
		drain();

		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
